### hdl/pbbg_pkg.sv
// Shared types and constants for the per-bin block gatherer.
// No dependencies; imported by per_bin_block_gatherer.
`default_nettype none

package pbbg_pkg;

   localparam int BINS_DEFAULT      = 256;
   localparam int BLOCK_LEN_DEFAULT = 15;

   localparam int BIN_FIELD_W  = 8;
   localparam int WORD_FIELD_W = 8;
   localparam int SLOT_FIELD_W = 4;

   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_FLUSH  = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [BIN_FIELD_W-1:0]  bin;
      logic [WORD_FIELD_W-1:0] word;
   } req_type;

   typedef struct packed {
      logic [BIN_FIELD_W-1:0]  out_bin;
      logic [WORD_FIELD_W-1:0] out_word;
      logic [SLOT_FIELD_W-1:0] slot;
      logic                    last;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/per_bin_block_gatherer.sv
// Per-bin block gatherer: fill-count memory, bin word store and result stream.
// Depends on pbbg_pkg.
`default_nettype none

// Words are gathered into BINS bins of BLOCK_LEN slots. For an append or flush,
// the bin's fill count is read from its memory in the accept cycle and written
// back in the next, unless a flush finds the bin empty. When an append fills a
// bin, or a flush hits a partial bin, the block then streams BLOCK_LEN results
// out of the word store at up to one per cycle (rsp_stall permitting), and takes
// no new item until the last of them is in the output register; that final
// result may still wait there while the next item is taken. Slots beyond the
// fill count are sent as zero, so the word store itself is never cleared. After
// reset the fill-count memory is cleared one bin per cycle, with req_stall held
// high. Items naming a bin at or above BINS are dropped in their accept cycle.
module per_bin_block_gatherer #(
   parameter int BINS      = pbbg_pkg::BINS_DEFAULT,
   parameter int BLOCK_LEN = pbbg_pkg::BLOCK_LEN_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  pbbg_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output pbbg_pkg::rsp_type rsp_payload
);

   import pbbg_pkg::*;

   localparam int BIN_W  = $clog2(BINS);
   localparam int CNT_W  = $clog2(BLOCK_LEN);
   localparam int EMIT_W = $clog2(BLOCK_LEN + 1);
   localparam int ADDR_W = $clog2(BINS * BLOCK_LEN);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_EMIT  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   // memories
   logic [CNT_W-1:0]        cnt_mem [BINS];
   logic [WORD_FIELD_W-1:0] store_mem [BINS * BLOCK_LEN];

   logic [CNT_W-1:0]        cnt_rd_ff;
   logic [WORD_FIELD_W-1:0] st_rd_ff;

   logic              cnt_re, cnt_we;
   logic [BIN_W-1:0]  cnt_raddr, cnt_waddr;
   logic [CNT_W-1:0]  cnt_wdata;
   logic              st_re, st_we;
   logic [ADDR_W-1:0] st_raddr, st_waddr, bin_base;

   // control and payload registers
   logic [2:0]              state_ff, state_in;
   logic [BIN_W-1:0]        clr_idx_ff, clr_idx_in;
   logic                    mode_ff, mode_in;
   logic [BIN_FIELD_W-1:0]  bin_ff, bin_in;
   logic [WORD_FIELD_W-1:0] word_ff, word_in;
   logic [EMIT_W-1:0]       emit_cnt_ff, emit_cnt_in;
   logic [CNT_W-1:0]        rd_slot_ff, rd_slot_in;
   logic                    pend_ff, pend_in;
   logic [CNT_W-1:0]        pend_slot_ff, pend_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic accept, in_range, out_free, issue, load;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign in_range    = (32'(req_payload.bin) < BINS);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign load        = pend_ff && out_free;
   assign issue       = (state_ff == ST_EMIT) && (!pend_ff || out_free);
   assign bin_base    = ADDR_W'(BIN_W'(bin_ff)) * ADDR_W'(BLOCK_LEN);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      mode_in      = mode_ff;
      bin_in       = bin_ff;
      word_in      = word_ff;
      emit_cnt_in  = emit_cnt_ff;
      rd_slot_in   = rd_slot_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      cnt_re    = 1'b0;
      cnt_raddr = BIN_W'(req_payload.bin);
      cnt_we    = 1'b0;
      cnt_waddr = BIN_W'(bin_ff);
      cnt_wdata = '0;
      st_re     = issue;
      st_raddr  = bin_base + ADDR_W'(rd_slot_ff);
      st_we     = 1'b0;
      st_waddr  = bin_base + ADDR_W'(cnt_rd_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we     = 1'b1;
            cnt_waddr  = clr_idx_ff;
            clr_idx_in = BIN_W'(clr_idx_ff + 1'b1);
            if (clr_idx_ff == BIN_W'(BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && in_range) begin
               cnt_re   = 1'b1;
               mode_in  = req_payload.mode;
               bin_in   = req_payload.bin;
               word_in  = req_payload.word;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            rd_slot_in = '0;
            if (mode_ff == MODE_FLUSH) begin
               if (cnt_rd_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_we      = 1'b1;
                  emit_cnt_in = EMIT_W'(cnt_rd_ff);
                  state_in    = ST_EMIT;
               end
            end else begin
               st_we  = 1'b1;
               cnt_we = 1'b1;
               if (cnt_rd_ff == CNT_W'(BLOCK_LEN - 1)) begin
                  emit_cnt_in = EMIT_W'(BLOCK_LEN);
                  state_in    = ST_EMIT;
               end else begin
                  cnt_wdata = CNT_W'(cnt_rd_ff + 1'b1);
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               rd_slot_in = CNT_W'(rd_slot_ff + 1'b1);
               if (rd_slot_ff == CNT_W'(BLOCK_LEN - 1)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // read pipeline: a slot issued last cycle waits in st_rd_ff until the
      // output register can take it
      if (issue) begin
         pend_in      = 1'b1;
         pend_slot_in = rd_slot_ff;
      end else if (load) begin
         pend_in = 1'b0;
      end

      if (load) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_bin  = bin_ff;
         rsp_in.out_word = (EMIT_W'(pend_slot_ff) < emit_cnt_ff) ? st_rd_ff : '0;
         rsp_in.slot     = SLOT_FIELD_W'(pend_slot_ff);
         rsp_in.last     = (pend_slot_ff == CNT_W'(BLOCK_LEN - 1));
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_waddr] <= word_ff;
      end
      if (st_re) begin
         st_rd_ff <= store_mem[st_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      bin_ff       <= bin_in;
      word_ff      <= word_in;
      emit_cnt_ff  <= emit_cnt_in;
      rd_slot_ff   <= rd_slot_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTHESIS
   // no results while the count memory is being cleared
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   // a fill count read back is always a legal slot index
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK |-> 32'(cnt_rd_ff) < BLOCK_LEN)
      else $error("fill count out of range");

   // pending read data held while the output register is blocked
   assert property (@(posedge clock) disable iff (reset)
      pend_ff && !out_free |=> pend_ff && $stable(pend_slot_ff) && $stable(st_rd_ff))
      else $error("pending read lost under stall");

   // a new item is only taken once the previous block is fully handed over
   assert property (@(posedge clock) disable iff (reset)
      accept |-> !pend_ff)
      else $error("item accepted during emission");
`endif

endmodule

`default_nettype wire

### sim/tb_per_bin_block_gatherer.sv
`timescale 1ns / 100ps
// Testbench for per_bin_block_gatherer: directed and random append/flush traffic
// with random stalls on both ends, checked word by word against a bin predictor.
// Depends on pbbg_pkg and the per_bin_block_gatherer RTL.

class gather_scoreboard;
   logic [pbbg_pkg::WORD_FIELD_W-1:0]
      bin_words [pbbg_pkg::BINS_DEFAULT][pbbg_pkg::BLOCK_LEN_DEFAULT];
   int unsigned fill_level [pbbg_pkg::BINS_DEFAULT];
   pbbg_pkg::rsp_type expected_words[$];
   int unsigned mismatches;

   function new();
      foreach (bin_words[b, s]) bin_words[b][s] = '0;
      foreach (fill_level[b]) fill_level[b] = 0;
      mismatches = 0;
   endfunction

   // Queue the whole bin in slot order, then clear it so unfilled slots read zero later.
   function void emit_block(logic [pbbg_pkg::BIN_FIELD_W-1:0] addr);
      pbbg_pkg::rsp_type word_out;
      for (int s = 0; s < pbbg_pkg::BLOCK_LEN_DEFAULT; s++) begin
         word_out.out_bin  = addr;
         word_out.out_word = bin_words[addr][s];
         word_out.slot     = s[pbbg_pkg::SLOT_FIELD_W-1:0];
         word_out.last     = (s == pbbg_pkg::BLOCK_LEN_DEFAULT - 1);
         expected_words.push_back(word_out);
         bin_words[addr][s] = '0;
      end
      fill_level[addr] = 0;
   endfunction

   function void note_request(pbbg_pkg::req_type item);
      int unsigned level;
      if (item.bin >= pbbg_pkg::BINS_DEFAULT) return;
      level = fill_level[item.bin];
      if (item.mode == pbbg_pkg::MODE_FLUSH) begin
         // an empty bin flushes to nothing
         if (level != 0) emit_block(item.bin);
      end else begin
         bin_words[item.bin][level] = item.word;
         if (level == pbbg_pkg::BLOCK_LEN_DEFAULT - 1) emit_block(item.bin);
         else fill_level[item.bin] = level + 1;
      end
   endfunction

   function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function void check_word(pbbg_pkg::rsp_type got);
      pbbg_pkg::rsp_type want;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
         mismatches++;
         return;
      end
      want = expected_words.pop_front();
      compare_field("out_bin", want.out_bin, got.out_bin);
      compare_field("out_word", want.out_word, got.out_word);
      compare_field("slot", want.slot, got.slot);
      compare_field("last", want.last, got.last);
   endfunction
endclass

module tb_per_bin_block_gatherer;
   import pbbg_pkg::*;

   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 80;
   localparam int PHASE_ITEMS   = 48;
   localparam int PHASES        = 6;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   gather_scoreboard board;
   int unsigned requests_taken = 0;
   int unsigned idle_cycles    = 0;
   bit          steady         = 1'b0;   // both sides run without gaps
   bit          long_hold_done = 1'b0;

   per_bin_block_gatherer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_request(input logic op, input logic [7:0] addr, input logic [7:0] data);
      req_type     item;
      int unsigned gap;
      item.mode = op;
      item.bin  = addr;
      item.word = data;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(item);
      requests_taken++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.expected_words.size() != 0);
   endtask

   // Mostly appends to two hot bins so blocks fill; the rest flushes and stray bins.
   task automatic random_phase(input int unsigned items);
      logic [7:0]  hot [2];
      int unsigned roll;
      foreach (hot[i]) hot[i] = 8'($urandom_range(0, 255));
      repeat (items) begin
         roll = $urandom_range(0, 99);
         if (roll < 80)
            send_request(MODE_APPEND, hot[$urandom_range(0, 1)], 8'($urandom_range(0, 255)));
         else if (roll < 87)
            send_request(MODE_FLUSH, hot[$urandom_range(0, 1)], 8'($urandom_range(0, 255)));
         else if (roll < 94)
            send_request(MODE_APPEND, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         else
            send_request(MODE_FLUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(MODE_APPEND, 8'h00, 8'hFF);
      send_request(MODE_APPEND, 8'hFF, 8'h00);
      send_request(MODE_FLUSH, 8'h00, 8'hA5);   // partial: one word, rest zero
      send_request(MODE_FLUSH, 8'h00, 8'h5A);   // already cleared
      send_request(MODE_FLUSH, 8'h80, 8'hFF);   // never written
      for (int i = 1; i < BLOCK_LEN_DEFAULT; i++)
         send_request(MODE_APPEND, 8'hFF, 8'(i * 8'h11));
      send_request(MODE_FLUSH, 8'hFF, 8'h00);   // emptied by the fill
      wait_for_results();

      for (int p = 0; p < PHASES; p++) begin
         steady = (p == 3);
         random_phase(PHASE_ITEMS);
         wait_for_results();
      end
      steady = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.expected_words.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Result side pacing; one long hold-off lets the block back up into its input.
   initial begin : result_pacing
      int unsigned hold;
      forever begin
         if (!long_hold_done && requests_taken >= HOLD_AFTER) begin
            hold = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else begin
            hold = steady ? 0 : $urandom_range(0, 5);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_word(rsp_payload);
   end

   // Any transfer on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

### sim.f
hdl/pbbg_pkg.sv
hdl/per_bin_block_gatherer.sv
sim/tb_per_bin_block_gatherer.sv
